>>> rtl/core/sfcd_pkg.sv
// Package for the sync-framed command deframer: phase codes, item and result
// types, sync constants and register reset value. No dependencies.
package sfcd_pkg;

    localparam logic [7:0]  SYNC_FIRST        = 8'h4D;
    localparam logic [7:0]  SYNC_SECOND       = 8'h43;
    localparam int          HIGH_SHIFT        = 8;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CMD     = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  frame_cmd;
        logic [15:0] frame_length;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        frame_end;
        logic        oversize;
    } out_item_t;

    // Result handed from the parser to the output buffer.
    typedef struct packed {
        logic      push;
        out_item_t item;
    } result_t;

endpackage

>>> rtl/core/sfcd_if.sv
// Handshake channels of the deframer: received-byte items and frame result
// items. Depends on sfcd_pkg.
interface sfcd_in_if;
    logic              valid;
    logic              ready;
    sfcd_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfcd_out_if;
    logic               valid;
    logic               ready;
    sfcd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/sfcd_parser.sv
// Frame parser: phase state machine, header registers, payload counter and
// the max_payload register. Depends on sfcd_pkg.
module sfcd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  sfcd_pkg::in_item_t  item,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output sfcd_pkg::result_t   result
);
    import sfcd_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  command_reg,  command_next;
    logic [15:0] length_reg,   length_next;
    logic [15:0] count_reg,    count_next;
    logic        discard_reg,  discard_next;
    logic [15:0] max_payload_reg;

    logic [15:0] full_length;
    logic [15:0] count_inc;
    logic        last;

    assign full_length = {item.rx_byte, length_reg[7:0]};
    assign count_inc   = count_reg + 16'd1;
    assign last        = count_inc >= length_reg;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        discard_next = discard_reg;
        if (item.kind)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                PH_SYNC2:
                begin
                    if (item.rx_byte == SYNC_SECOND)
                        phase_next = PH_CMD;
                    else if (item.rx_byte != SYNC_FIRST)
                        phase_next = PH_HUNT;
                end
                PH_CMD:
                begin
                    command_next = item.rx_byte;
                    phase_next   = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {8'd0, item.rx_byte};
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next  = full_length;
                    count_next   = 16'd0;
                    discard_next = full_length > max_payload_reg;
                    phase_next   = (full_length == 16'd0) ? PH_HUNT : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    count_next = count_inc;
                    if (last)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (item.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    // Result
    always_comb
    begin
        result                     = '0;
        result.item.frame_cmd      = command_reg;
        result.item.frame_length   = length_reg;
        if (!item.kind)
        begin
            unique case (phase_reg)
                PH_LEN_HI:
                begin
                    result.item.frame_length = full_length;
                    if (full_length == 16'd0)
                    begin
                        result.push           = 1'b1;
                        result.item.frame_end = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (discard_reg)
                    begin
                        result.push           = last;
                        result.item.frame_end = 1'b1;
                        result.item.oversize  = 1'b1;
                    end
                    else
                    begin
                        result.push                = 1'b1;
                        result.item.payload_valid  = 1'b1;
                        result.item.payload_byte   = item.rx_byte;
                        result.item.payload_offset = count_reg;
                        result.item.frame_end      = last;
                    end
                end
                default:
                begin
                    result.push = 1'b0;
                end
            endcase
        end
        result.push = result.push & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            command_reg <= 8'd0;
            length_reg  <= 16'd0;
            count_reg   <= 16'd0;
            discard_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_we)
            max_payload_reg <= cfg_wdata;
    end

endmodule

>>> rtl/core/sfcd_out_buf.sv
// Result register with a skid stage so the input side keeps moving while a
// result waits. Depends on sfcd_pkg and sfcd_if.
module sfcd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  sfcd_pkg::result_t result,
    output logic              room,
    sfcd_out_if.source        frame_stream
);
    import sfcd_pkg::*;

    logic      out_valid_reg,  out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg,   out_data_next;
    out_item_t skid_data_reg,  skid_data_next;
    logic      pop;

    assign pop                = out_valid_reg && frame_stream.ready;
    assign room               = !skid_valid_reg;
    assign frame_stream.valid = out_valid_reg;
    assign frame_stream.data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = result.push;
                if (result.push)
                    skid_data_next = result.item;
            end
            else
            begin
                out_valid_next = result.push;
                out_data_next  = result.item;
            end
        end
        else if (result.push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/core/sync_framed_command_deframer_top.sv
// Top level of the sync-framed command deframer: parser plus output buffer.
// Depends on sfcd_pkg, sfcd_if, sfcd_parser and sfcd_out_buf.
//
//   channel        dir   handshake            carries
//   byte_stream    sink  valid/ready          kind, rx_byte
//   frame_stream   src   valid/ready          frame_cmd .. oversize
//   cfg_we/wdata   sink  write enable only    max_payload
//
// One item per cycle while byte_stream ready is high. Results are registered
// in the output register; when frame_stream stalls, one more is held in the
// skid stage, and byte_stream ready drops only while it is full. Header bytes
// give no result unless the length is zero; an oversize frame gives only its
// end. Throughput is set by the parser step and the two-entry output buffer.
// Reset (rst_n low, asynchronous) returns the parser to hunting, clears the
// header registers and sets max_payload to 256.
module sync_framed_command_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    sfcd_in_if.sink      byte_stream,
    sfcd_out_if.source   frame_stream,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);
    import sfcd_pkg::*;

    result_t result;
    logic    room;
    logic    accept;

    // Take a byte whenever the skid stage is free to absorb its result.
    assign byte_stream.ready = room;
    assign accept            = byte_stream.valid && room;

    // Advance the phase machine and build the result for the accepted item.
    sfcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (byte_stream.data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // Hold results until the downstream side takes them.
    sfcd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .room         (room),
        .frame_stream (frame_stream)
    );

endmodule
